>>> rtl/core/cse_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cross stencil sharpen/edge filter.
// Used by the filter top level and its port checker; depends on nothing.
package cse_pkg;

  localparam int PIX_BITS      = 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 40;

  localparam int FW_BITS   = 11;
  localparam int FH_BITS   = 13;
  localparam int WT_BITS   = 40;
  localparam int TH_BITS   = 8;
  localparam int ROW_BITS  = 12;
  localparam int TAPS      = 5;
  localparam int LUMA_BITS = 24;

  localparam logic [FH_BITS-1:0] MAX_ROWS = 13'd4096;

  localparam logic [FW_BITS-1:0] FW_RESET = 11'd1024;
  localparam logic [FH_BITS-1:0] FH_RESET = 13'd1024;
  localparam logic [WT_BITS-1:0] WT_RESET = 40'hF0_F050_F0F0;
  localparam logic [TH_BITS-1:0] TH_RESET = 8'd0;

  // BT.601 luma weights in Q0.16.
  localparam logic [15:0] LUMA_R = 16'd19595;
  localparam logic [15:0] LUMA_G = 16'd38470;
  localparam logic [15:0] LUMA_B = 16'd7471;

  typedef logic [PIX_BITS-1:0] pix_t;

  // Index 2 is red, 1 is green, 0 is blue.
  typedef logic [2:0][PIX_BITS-1:0] rgb_t;

  typedef struct packed {
    logic mode;
    pix_t in_red;
    pix_t in_green;
    pix_t in_blue;
  } in_item_t;

  typedef struct packed {
    pix_t out_red;
    pix_t out_green;
    pix_t out_blue;
    logic end_of_frame;
  } out_item_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH     = 3'd0,
    REG_FRAME_HEIGHT    = 3'd1,
    REG_FILTER_MODE     = 3'd2,
    REG_STENCIL_WEIGHTS = 3'd3,
    REG_EDGE_THRESHOLD  = 3'd4
  } cfg_reg_t;

  // Where the left neighbor of an item comes from.
  typedef enum logic [1:0] {
    LEFT_CENTER,
    LEFT_TWO_ABOVE,
    LEFT_ABOVE,
    LEFT_PREV
  } left_src_t;

  function automatic logic [LUMA_BITS-1:0] luma(input rgb_t p);
    logic [LUMA_BITS-1:0] pr;
    logic [LUMA_BITS-1:0] pg;
    logic [LUMA_BITS-1:0] pb;
    pr = LUMA_BITS'(LUMA_R) * LUMA_BITS'(p[2]);
    pg = LUMA_BITS'(LUMA_G) * LUMA_BITS'(p[1]);
    pb = LUMA_BITS'(LUMA_B) * LUMA_BITS'(p[0]);
    return pr + pg + pb;
  endfunction

endpackage

>>> rtl/core/cross_stencil_sharpen_edge.sv
`timescale 1ns / 1ps
// Five-point cross stencil filter (sharpen or luma edge) on a raster RGB stream.
// Depends on cse_pkg for item types, register codes and the luma function.

// One item is taken every clock while the result buffer has room. Both line
// memories are read in the cycle an item is taken; line_above is written in
// that cycle and line_two_above from stage 1. Each of the two line memories
// has one write and two read ports, so no pattern of columns slows the
// stream. A result passes stages 1 to 3 and the result buffer on its way to
// out_valid. Results lag the input by one row: the pixel of row r comes out
// with row r+1, and drain items (mode 1) give the last row, the final one
// flagged end_of_frame. An eight-entry result buffer absorbs output stalls;
// in_ready drops once eight results are outstanding. Configuration writes
// are taken every clock. The line memories need no clearing after reset.
module cross_stencil_sharpen_edge #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  cse_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output cse_pkg::out_item_t                  out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cse_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [cse_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int AW         = $clog2(MAX_WIDTH);
  localparam int CW         = $clog2(MAX_WIDTH + 1);
  localparam int CMPW       = (CW > cse_pkg::FW_BITS) ? CW : cse_pkg::FW_BITS;
  localparam int FIFO_DEPTH = 8;
  localparam int FP_BITS    = $clog2(FIFO_DEPTH);
  localparam int OCC_BITS   = $clog2(FIFO_DEPTH + 1);
  localparam int SP_BITS    = 17;
  localparam int SS_BITS    = 20;
  localparam int EP_BITS    = 33;
  localparam int ES_BITS    = 36;

  // Configuration registers.
  logic [cse_pkg::FW_BITS-1:0] frame_width;
  logic [cse_pkg::FH_BITS-1:0] frame_height;
  logic                        filter_mode;
  logic [cse_pkg::WT_BITS-1:0] stencil_weights;
  logic [cse_pkg::TH_BITS-1:0] edge_threshold;

  // Raster position.
  logic [AW-1:0]                column_count;
  logic [AW-1:0]                drain_count;
  logic [cse_pkg::ROW_BITS-1:0] row_count;
  logic                         frame_full;

  // Line memories.
  cse_pkg::rgb_t line_above     [MAX_WIDTH];
  cse_pkg::rgb_t line_two_above [MAX_WIDTH];
  cse_pkg::rgb_t ma_qa;
  cse_pkg::rgb_t ma_qb;
  cse_pkg::rgb_t mb_qa;
  cse_pkg::rgb_t mb_qb;

  logic [CMPW-1:0]             fw_ext;
  logic [CW-1:0]               eff_w;
  logic [cse_pkg::FH_BITS-1:0] eff_h;
  logic [AW-1:0]               count_sel;
  logic [AW-1:0]               col;
  logic [AW-1:0]               col_inc;
  logic [AW-1:0]               col_dec;
  logic [AW-1:0]               ma_rb;
  logic [AW-1:0]               mb_rb;
  logic [CW-1:0]               col_plus;
  logic [cse_pkg::FH_BITS-1:0] row_plus;
  logic                        col_zero;
  logic                        last_col;
  logic                        last_row;
  logic                        take;
  logic                        pix_act;
  logic                        drn_act;
  logic                        produce;
  logic                        up_ok;
  cse_pkg::left_src_t          left_src;
  cse_pkg::rgb_t               cur;

  // Stage 1: memory data returns.
  logic               s1_res;
  logic               s1_wr;
  logic [AW-1:0]      s1_col;
  logic               s1_drain;
  cse_pkg::rgb_t      s1_cur;
  cse_pkg::left_src_t s1_left;
  logic               s1_right_ok;
  logic               s1_up_ok;
  logic               s1_eof;
  logic               s1_fwd_up;
  logic               s1_fwd_left;
  cse_pkg::rgb_t      fwd_data;
  cse_pkg::rgb_t      prev_center;
  cse_pkg::rgb_t      nb [cse_pkg::TAPS];

  // Stage 2: neighbors and their luma.
  logic                            s2_res;
  logic                            s2_eof;
  cse_pkg::rgb_t                   s2_nb   [cse_pkg::TAPS];
  logic [cse_pkg::LUMA_BITS-1:0]   s2_luma [cse_pkg::TAPS];
  logic signed [7:0]               wt      [cse_pkg::TAPS];

  // Stage 3: products.
  logic                        s3_res;
  logic                        s3_eof;
  logic signed [SP_BITS-1:0]   s3_sp [3][cse_pkg::TAPS];
  logic signed [EP_BITS-1:0]   s3_ep [cse_pkg::TAPS];
  cse_pkg::out_item_t          res_item;

  // Result buffer.
  cse_pkg::out_item_t  fifo_mem [FIFO_DEPTH];
  logic [FP_BITS-1:0]  wr_ptr;
  logic [FP_BITS-1:0]  rd_ptr;
  logic [OCC_BITS-1:0] fifo_cnt;
  logic [OCC_BITS-1:0] occ;
  logic                pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= cse_pkg::FW_RESET;
      frame_height    <= cse_pkg::FH_RESET;
      filter_mode     <= 1'b0;
      stencil_weights <= cse_pkg::WT_RESET;
      edge_threshold  <= cse_pkg::TH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cse_pkg::REG_FRAME_WIDTH:     frame_width     <= cfg_data[cse_pkg::FW_BITS-1:0];
        cse_pkg::REG_FRAME_HEIGHT:    frame_height    <= cfg_data[cse_pkg::FH_BITS-1:0];
        cse_pkg::REG_FILTER_MODE:     filter_mode     <= cfg_data[0];
        cse_pkg::REG_STENCIL_WEIGHTS: stencil_weights <= cfg_data[cse_pkg::WT_BITS-1:0];
        cse_pkg::REG_EDGE_THRESHOLD:  edge_threshold  <= cfg_data[cse_pkg::TH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: zero counts as one, and oversize values clamp.
  assign fw_ext = CMPW'(frame_width);

  always_comb begin
    if (fw_ext == '0) begin
      eff_w = CW'(1);
    end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(fw_ext);
    end
    if (frame_height == '0) begin
      eff_h = cse_pkg::FH_BITS'(1);
    end else if (frame_height > cse_pkg::MAX_ROWS) begin
      eff_h = cse_pkg::MAX_ROWS;
    end else begin
      eff_h = frame_height;
    end
  end

  // A count at or beyond the width (after a width change) acts as the last column.
  assign count_sel = frame_full ? drain_count : column_count;
  assign col       = (CW'(count_sel) >= eff_w) ? AW'(eff_w - CW'(1)) : count_sel;
  assign col_plus  = CW'(col) + CW'(1);
  assign col_inc   = col_plus[AW-1:0];
  assign col_dec   = col - AW'(1);
  assign col_zero  = (col == '0);
  assign last_col  = (col_plus >= eff_w);
  assign row_plus  = cse_pkg::FH_BITS'(row_count) + cse_pkg::FH_BITS'(1);
  assign last_row  = (row_plus >= eff_h);

  assign in_ready = (occ < OCC_BITS'(FIFO_DEPTH));
  assign take     = in_valid && in_ready;
  assign pix_act  = take && !in_item.mode && !frame_full;
  assign drn_act  = take && in_item.mode && frame_full;
  assign produce  = (pix_act && (row_count != '0)) || drn_act;
  assign cur      = {in_item.in_red, in_item.in_green, in_item.in_blue};
  assign up_ok    = frame_full ? (row_count != '0) : (row_count > cse_pkg::ROW_BITS'(1));

  // While draining, the second read port of line_above serves the left
  // neighbor on the last column, where no right neighbor is needed.
  assign ma_rb = last_col ? (col_zero ? col : col_dec) : col_inc;
  assign mb_rb = col_zero ? col : col_dec;

  always_comb begin
    if (col_zero) begin
      left_src = cse_pkg::LEFT_CENTER;
    end else if (!frame_full) begin
      left_src = cse_pkg::LEFT_TWO_ABOVE;
    end else if (last_col) begin
      left_src = cse_pkg::LEFT_ABOVE;
    end else begin
      left_src = cse_pkg::LEFT_PREV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      drain_count  <= '0;
      row_count    <= '0;
      frame_full   <= 1'b0;
    end else if (pix_act) begin
      if (last_col) begin
        column_count <= '0;
        if (last_row) begin
          frame_full  <= 1'b1;
          drain_count <= '0;
        end else begin
          row_count <= row_count + cse_pkg::ROW_BITS'(1);
        end
      end else begin
        column_count <= col_inc;
      end
    end else if (drn_act) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= '0;
        drain_count  <= '0;
        frame_full   <= 1'b0;
      end else begin
        drain_count <= col_inc;
      end
    end
  end

  // line_above takes the new pixel at once; reads return the old contents.
  always_ff @(posedge clk) begin
    if (pix_act) begin
      line_above[col] <= cur;
    end
    ma_qa <= line_above[col];
    ma_qb <= line_above[ma_rb];
  end

  // line_two_above is written in the cycle after line_above, with the old line_above entry.
  always_ff @(posedge clk) begin
    if (s1_wr) begin
      line_two_above[s1_col] <= ma_qa;
    end
    mb_qa <= line_two_above[col];
    mb_qb <= line_two_above[mb_rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_res <= 1'b0;
      s1_wr  <= 1'b0;
    end else begin
      s1_res <= produce;
      s1_wr  <= pix_act;
    end
  end

  // The write of the item ahead lands in the same cycle as these reads, so
  // a matching address takes the written value instead.
  always_ff @(posedge clk) begin
    s1_col      <= col;
    s1_drain    <= frame_full;
    s1_cur      <= cur;
    s1_left     <= left_src;
    s1_right_ok <= !last_col;
    s1_up_ok    <= up_ok;
    s1_eof      <= frame_full && last_col;
    s1_fwd_up   <= s1_wr && (s1_col == col);
    s1_fwd_left <= s1_wr && (s1_col == col_dec);
    fwd_data    <= ma_qa;
    if (s1_res && s1_drain) begin
      prev_center <= ma_qa;
    end
  end

  always_comb begin
    unique case (s1_left)
      cse_pkg::LEFT_CENTER:    nb[0] = ma_qa;
      cse_pkg::LEFT_TWO_ABOVE: nb[0] = s1_fwd_left ? fwd_data : mb_qb;
      cse_pkg::LEFT_ABOVE:     nb[0] = ma_qb;
      cse_pkg::LEFT_PREV:      nb[0] = prev_center;
      default:                 nb[0] = ma_qa;
    endcase
    nb[1] = s1_right_ok ? ma_qb : ma_qa;
    nb[2] = ma_qa;
    nb[3] = s1_up_ok ? (s1_fwd_up ? fwd_data : mb_qa) : ma_qa;
    nb[4] = s1_drain ? ma_qa : s1_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_res <= 1'b0;
    end else begin
      s2_res <= s1_res;
    end
  end

  always_ff @(posedge clk) begin
    s2_eof <= s1_eof;
    for (int i = 0; i < cse_pkg::TAPS; i++) begin
      s2_nb[i]   <= nb[i];
      s2_luma[i] <= cse_pkg::luma(nb[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < cse_pkg::TAPS; i++) begin
      wt[i] = signed'(stencil_weights[8*i +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_res <= 1'b0;
    end else begin
      s3_res <= s2_res;
    end
  end

  always_ff @(posedge clk) begin
    s3_eof <= s2_eof;
    for (int i = 0; i < cse_pkg::TAPS; i++) begin
      for (int k = 0; k < 3; k++) begin
        s3_sp[k][i] <= wt[i] * signed'({1'b0, s2_nb[i][k]});
      end
      s3_ep[i] <= wt[i] * signed'({1'b0, s2_luma[i]});
    end
  end

  // Sum, round half up and saturate per channel, or threshold the luma sum.
  always_comb begin
    logic signed [SS_BITS-1:0] ssum;
    logic signed [ES_BITS-1:0] esum;
    logic signed [ES_BITS-1:0] thr;
    logic [SS_BITS-5:0]        shifted;
    logic [2:0][cse_pkg::PIX_BITS-1:0] sat;
    cse_pkg::pix_t             edge_val;
    esum = '0;
    for (int i = 0; i < cse_pkg::TAPS; i++) begin
      esum = esum + s3_ep[i];
    end
    thr      = signed'(ES_BITS'({edge_threshold, 20'b0}));
    edge_val = (esum > thr) ? '1 : '0;
    for (int k = 0; k < 3; k++) begin
      ssum = SS_BITS'(8);
      for (int i = 0; i < cse_pkg::TAPS; i++) begin
        ssum = ssum + s3_sp[k][i];
      end
      shifted = ssum[SS_BITS-1:4];
      if (ssum < 0) begin
        sat[k] = '0;
      end else if (shifted > (SS_BITS-4)'(255)) begin
        sat[k] = '1;
      end else begin
        sat[k] = shifted[cse_pkg::PIX_BITS-1:0];
      end
    end
    if (filter_mode) begin
      res_item.out_red   = edge_val;
      res_item.out_green = edge_val;
      res_item.out_blue  = edge_val;
    end else begin
      res_item.out_red   = sat[2];
      res_item.out_green = sat[1];
      res_item.out_blue  = sat[0];
    end
    res_item.end_of_frame = s3_eof;
  end

  // Result buffer; occ counts every result promised and not yet delivered,
  // so the buffer can never overflow.
  assign out_valid = (fifo_cnt != '0);
  assign out_item  = fifo_mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (s3_res) begin
      fifo_mem[wr_ptr] <= res_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      occ      <= '0;
    end else begin
      if (s3_res) begin
        wr_ptr <= wr_ptr + FP_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FP_BITS'(1);
      end
      fifo_cnt <= fifo_cnt + OCC_BITS'(s3_res) - OCC_BITS'(pop);
      occ      <= occ + OCC_BITS'(produce) - OCC_BITS'(pop);
    end
  end

endmodule

>>> rtl/core/cse_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the cross stencil filter, bound to its top level.
// Depends on cse_pkg for the result item type.
module cse_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input cse_pkg::out_item_t out_item
);

  // A stalled result stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed or dropped while stalled");

  // Leaving reset, the block is empty and ready.
  a_reset_state: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_ready && !out_valid)
    else $error("block not empty after reset");

  // A result appears on an empty output only after its item has passed the pipeline stages.
  a_out_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 4))
    else $error("result item appeared without an item taken four clocks earlier");

  // The input only stalls when the result buffer has something to deliver.
  a_full_pending: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result item pending");

endmodule

bind cross_stencil_sharpen_edge cse_checker u_cse_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the cross stencil sharpen/edge filter.
// Depends on cse_pkg and cross_stencil_sharpen_edge; has its own pixel predictor.
module tb_top;
  import cse_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 4096;
  localparam int PIX_MAX = 255;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1350;
  localparam int MAX_REPORTS = 100;

  localparam logic ITEM_PIXEL = 1'b0;
  localparam logic ITEM_DRAIN = 1'b1;
  localparam logic MODE_SHARPEN = 1'b0;
  localparam logic MODE_EDGE = 1'b1;

  localparam longint LUMA_R_Q16 = 19595;
  localparam longint LUMA_G_Q16 = 38470;
  localparam longint LUMA_B_Q16 = 7471;
  localparam longint EDGE_SCALE = 1048576;

  // Weight sets, bytes from the top: down, up, centre, right, left.
  localparam logic [WT_BITS-1:0] WT_LAPLACE = 40'hF0_F0_40_F0_F0;
  localparam logic [WT_BITS-1:0] WT_HALF_CENTER = 40'h00_00_08_00_00;
  localparam logic [WT_BITS-1:0] WT_UNIT_CENTER = 40'h00_00_10_00_00;
  localparam logic [WT_BITS-1:0] WT_EXTREME = 40'h80_80_7F_80_80;
  localparam logic [WT_BITS-1:0] WT_ALL_MAX = 40'h7F_7F_7F_7F_7F;

  // Index 2 is red, 1 is green, 0 is blue.
  typedef logic [2:0][7:0] px3_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  cross_stencil_sharpen_edge u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow of the configuration registers.
  logic [FW_BITS-1:0] cfg_w = FW_RESET;
  logic [FH_BITS-1:0] cfg_h = FH_RESET;
  logic cfg_mode = MODE_SHARPEN;
  logic [WT_BITS-1:0] cfg_wts = WT_RESET;
  logic [TH_BITS-1:0] cfg_th = TH_RESET;

  // Line history and raster position as the block should hold them.
  px3_t row_up [MAX_W];
  px3_t row_up2 [MAX_W];
  int unsigned col_n = 0;
  int unsigned row_n = 0;
  int unsigned drain_n = 0;
  bit frame_full = 1'b0;

  out_item_t pending_px [$];
  out_item_t want_px;

  int unsigned faults = 0;
  int unsigned items_in = 0;
  int unsigned results_seen = 0;
  int unsigned frames_done = 0;
  int unsigned reg_writes = 0;
  bit calm_tx = 1'b0;

  function automatic int unsigned eff_w();
    if (cfg_w == 0) return 1;
    if (cfg_w > MAX_W) return MAX_W;
    return cfg_w;
  endfunction

  function automatic int unsigned eff_h();
    if (cfg_h == 0) return 1;
    if (cfg_h > MAX_H) return MAX_H;
    return cfg_h;
  endfunction

  function automatic longint tap(input int i);
    return longint'($signed(cfg_wts[8*i +: 8]));
  endfunction

  function automatic longint luma(input px3_t p);
    return LUMA_R_Q16 * longint'(p[2]) + LUMA_G_Q16 * longint'(p[1])
      + LUMA_B_Q16 * longint'(p[0]);
  endfunction

  // Neighbors in order left, right, centre, up, down.
  function automatic out_item_t apply_stencil(input px3_t [4:0] nb, input bit eof);
    out_item_t o;
    px3_t res;
    longint acc;
    longint v;
    if (cfg_mode == MODE_SHARPEN) begin
      for (int k = 0; k < 3; k++) begin
        acc = 8;
        for (int i = 0; i < TAPS; i++) acc += tap(i) * longint'(nb[i][k]);
        v = (acc < 0) ? 0 : (acc >>> 4);
        if (v > PIX_MAX) v = PIX_MAX;
        res[k] = v[7:0];
      end
    end else begin
      acc = 0;
      for (int i = 0; i < TAPS; i++) acc += tap(i) * luma(nb[i]);
      res = (acc > longint'(cfg_th) * EDGE_SCALE) ? '1 : '0;
    end
    o.out_red = res[2];
    o.out_green = res[1];
    o.out_blue = res[0];
    o.end_of_frame = eof;
    return o;
  endfunction

  // Updates the line history for one accepted item and queues its result, if any.
  task automatic advance_stencil(input in_item_t it);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    px3_t cur;
    px3_t ctr;
    px3_t [4:0] nb;
    bit last;
    w = eff_w();
    h = eff_h();
    if (it.mode == ITEM_PIXEL) begin
      if (frame_full) return;
      cur = {it.in_red, it.in_green, it.in_blue};
      c = (col_n >= w) ? w - 1 : col_n;
      if (row_n > 0) begin
        ctr = row_up[c];
        // The left neighbor of the row above has already moved to the older line.
        nb[0] = (c > 0) ? row_up2[c-1] : ctr;
        nb[1] = (c + 1 < w) ? row_up[c+1] : ctr;
        nb[2] = ctr;
        nb[3] = (row_n > 1) ? row_up2[c] : ctr;
        nb[4] = cur;
        pending_px.push_back(apply_stencil(nb, 1'b0));
      end
      row_up2[c] = row_up[c];
      row_up[c] = cur;
      if (c + 1 >= w) begin
        col_n = 0;
        if (row_n + 1 >= h) begin
          frame_full = 1'b1;
          drain_n = 0;
        end else begin
          row_n++;
        end
      end else begin
        col_n = c + 1;
      end
    end else begin
      if (!frame_full) return;
      c = (drain_n >= w) ? w - 1 : drain_n;
      ctr = row_up[c];
      last = (c + 1 >= w);
      nb[0] = (c > 0) ? row_up[c-1] : ctr;
      nb[1] = last ? ctr : row_up[c+1];
      nb[2] = ctr;
      nb[3] = (row_n > 0) ? row_up2[c] : ctr;
      nb[4] = ctr;
      pending_px.push_back(apply_stencil(nb, last));
      if (last) begin
        col_n = 0;
        row_n = 0;
        drain_n = 0;
        frame_full = 1'b0;
        frames_done++;
      end else begin
        drain_n = c + 1;
      end
    end
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = (calm_tx || $urandom_range(0, 99) < 55) ? 0 : gap_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    items_in++;
    advance_stencil(it);
  endtask

  task automatic send_px(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    in_item_t it;
    it.mode = ITEM_PIXEL;
    it.in_red = r;
    it.in_green = g;
    it.in_blue = b;
    send_item(it);
  endtask

  task automatic send_drain();
    in_item_t it;
    it.mode = ITEM_DRAIN;
    it.in_red = 8'($urandom);
    it.in_green = 8'($urandom);
    it.in_blue = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_random_px();
    send_px(8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Random pixels until the frame is complete, then the drain items.
  task automatic fill_and_drain();
    while (!frame_full) send_random_px();
    while (frame_full) send_drain();
  endtask

  // Stops the input and lets every pending result and the pipeline empty out.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    case (idx)
      REG_FRAME_WIDTH: cfg_w = val[FW_BITS-1:0];
      REG_FRAME_HEIGHT: cfg_h = val[FH_BITS-1:0];
      REG_FILTER_MODE: cfg_mode = val[0];
      REG_STENCIL_WEIGHTS: cfg_wts = val[WT_BITS-1:0];
      REG_EDGE_THRESHOLD: cfg_th = val[TH_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h, input logic m);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_FILTER_MODE, m);
  endtask

  // Output side: random stalls, with stretches where the receiver starts no new stall.
  int unsigned stall_left = 0;
  int unsigned phase_left = 0;
  bit calm_rx = 1'b0;
  always @(negedge clk) begin
    if (phase_left == 0) begin
      calm_rx = ($urandom_range(0, 3) == 0);
      phase_left = $urandom_range(100, 400);
    end else begin
      phase_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm_rx && $urandom_range(0, 99) < 20) begin
      stall_left = gap_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic report_field(input string fname, input logic [7:0] want,
                              input logic [7:0] got);
    if (want !== got) begin
      faults++;
      if (faults <= MAX_REPORTS)
        $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_px.size() == 0) begin
        faults++;
        if (faults <= MAX_REPORTS)
          $display("%0t: result with no pixel pending, expected none, got %p",
                   $time, out_item);
      end else begin
        want_px = pending_px.pop_front();
        report_field("out_red", want_px.out_red, out_item.out_red);
        report_field("out_green", want_px.out_green, out_item.out_green);
        report_field("out_blue", want_px.out_blue, out_item.out_blue);
        report_field("end_of_frame", 8'(want_px.end_of_frame), 8'(out_item.end_of_frame));
        results_seen++;
      end
    end
  end

  // Starts at the reset geometry, then shrinks width mid-row and height mid-frame.
  task automatic test_reset_defaults();
    send_drain();
    send_px(8'd0, 8'd0, 8'd0);
    send_px(8'd255, 8'd255, 8'd255);
    send_px(8'h55, 8'hAA, 8'h0F);
    send_px(8'hAA, 8'h55, 8'hF0);
    settle();
    write_reg(REG_FRAME_WIDTH, 3);
    send_px(8'h12, 8'h34, 8'h56);
    settle();
    write_reg(REG_FRAME_HEIGHT, 0);
    send_px(8'd255, 8'd0, 8'd255);
    send_px(8'd0, 8'd255, 8'd0);
    send_px(8'd128, 8'd127, 8'd1);
    // The frame is full now, so this pixel must be dropped.
    send_px(8'd1, 8'd2, 8'd3);
    fill_and_drain();
  endtask

  task automatic test_sharpen_extremes();
    logic [7:0] v;
    settle();
    set_frame(4, 3, MODE_SHARPEN);
    write_reg(REG_STENCIL_WEIGHTS, WT_EXTREME);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        v = ((r + c) % 2 == 1) ? 8'd255 : 8'd0;
        send_px(v, ~v, v);
      end
    end
    fill_and_drain();
    // Half weight on the centre checks the round-half-up step.
    settle();
    set_frame(2, 2, MODE_SHARPEN);
    write_reg(REG_STENCIL_WEIGHTS, WT_HALF_CENTER);
    fill_and_drain();
  endtask

  task automatic test_edge_threshold();
    settle();
    set_frame(3, 2, MODE_EDGE);
    write_reg(REG_STENCIL_WEIGHTS, WT_LAPLACE);
    write_reg(REG_EDGE_THRESHOLD, 0);
    fill_and_drain();
    // White under unit weight lands exactly on a threshold of 255: not above it.
    settle();
    set_frame(2, 1, MODE_EDGE);
    write_reg(REG_STENCIL_WEIGHTS, WT_UNIT_CENTER);
    write_reg(REG_EDGE_THRESHOLD, 255);
    send_px(8'd255, 8'd255, 8'd255);
    send_px(8'd255, 8'd255, 8'd255);
    fill_and_drain();
    settle();
    write_reg(REG_EDGE_THRESHOLD, 254);
    send_px(8'd255, 8'd255, 8'd255);
    send_px(8'd255, 8'd255, 8'd255);
    fill_and_drain();
    settle();
    set_frame(2, 2, MODE_EDGE);
    write_reg(REG_STENCIL_WEIGHTS, WT_ALL_MAX);
    write_reg(REG_EDGE_THRESHOLD, 128);
    fill_and_drain();
  endtask

  // Zero and oversized register values, and the largest frame sizes.
  task automatic test_frame_limits();
    calm_tx = 1'b1;
    settle();
    set_frame(0, 1, MODE_SHARPEN);
    write_reg(REG_STENCIL_WEIGHTS, 40'({$urandom, $urandom}));
    fill_and_drain();
    settle();
    set_frame(2047, 1, MODE_SHARPEN);
    fill_and_drain();
    settle();
    set_frame(1, 8191, MODE_EDGE);
    write_reg(REG_EDGE_THRESHOLD, $urandom_range(0, 255));
    fill_and_drain();
    calm_tx = 1'b0;
  endtask

  task automatic random_weights();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) write_reg(REG_STENCIL_WEIGHTS, WT_RESET);
    else if (r < 40) write_reg(REG_STENCIL_WEIGHTS, WT_LAPLACE);
    else write_reg(REG_STENCIL_WEIGHTS, 40'({$urandom, $urandom}));
  endtask

  task automatic random_threshold();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) write_reg(REG_EDGE_THRESHOLD, 0);
    else if (r == 1) write_reg(REG_EDGE_THRESHOLD, 255);
    else write_reg(REG_EDGE_THRESHOLD, $urandom_range(0, 255));
  endtask

  task automatic test_random_frames();
    int unsigned counted;
    int unsigned w;
    int unsigned h;
    bit changed;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      settle();
      calm_tx = ($urandom_range(0, 3) == 0);
      w = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 80);
      if ($urandom_range(0, 49) == 0) w = 0;
      h = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 20);
      if ($urandom_range(0, 29) == 0) h = 0;
      set_frame(w, h, 1'($urandom));
      random_weights();
      random_threshold();
      changed = 1'b0;
      while (!frame_full) begin
        if (!changed && $urandom_range(0, 39) == 0) begin
          // Mid-frame retune; the width may only shrink here.
          changed = 1'b1;
          settle();
          write_reg(REG_FILTER_MODE, 1'($urandom));
          random_weights();
          random_threshold();
          if ($urandom_range(0, 1) == 1) write_reg(REG_FRAME_WIDTH, $urandom_range(0, eff_w()));
          if ($urandom_range(0, 1) == 1) write_reg(REG_FRAME_HEIGHT, $urandom_range(0, 10));
        end
        if ($urandom_range(0, 24) == 0) send_drain();
        send_random_px();
        counted++;
      end
      if ($urandom_range(0, 2) == 0) send_random_px();
      while (frame_full) begin
        send_drain();
        counted++;
      end
    end
    calm_tx = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_sharpen_extremes();
    test_edge_threshold();
    test_frame_limits();
    test_random_frames();
    settle();
    $display("Checked %0d filtered pixels in %0d frames from %0d accepted items and %0d writes.",
             results_seen, frames_done, items_in, reg_writes);
    $display("Both filter modes, clamped frame sizes, mid-frame resizing and dropped items ran.");
    if (faults == 0) begin
      $display("cross_stencil_sharpen_edge verification clean");
    end else begin
      $display("cross_stencil_sharpen_edge verification failed");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timed out with %0d results still pending.", pending_px.size());
    $display("cross_stencil_sharpen_edge verification failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/cse_pkg.sv
rtl/core/cross_stencil_sharpen_edge.sv
rtl/core/cse_checker.sv
verif/tb_top.sv
